>>> hw/rtl/servo_write_packet_framer_assert.svh
// Assertion macros used by the packet framer back end.
`ifndef SERVO_WRITE_PACKET_FRAMER_ASSERT_SVH
`define SERVO_WRITE_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SWPF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define SWPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/swpf_pkg.sv
// Types, constants and the CRC-16 byte update for the packet framer.
package swpf_pkg;

    // Defaults and fixed sizes
    localparam int unsigned MAX_DATA_DEF = 4;
    localparam int unsigned DATA_FIELDS  = 4;
    // Command queue depth, a power of two
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

    // Header and CRC constants
    localparam logic [7:0]  HDR_SYNC = 8'hFF;
    localparam logic [7:0]  HDR_MARK = 8'hFD;
    localparam logic [7:0]  HDR_RSVD = 8'h00;
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [7:0]  LEN_BASE = 8'd5;

    // Byte positions in the packet
    localparam logic [3:0] POS_SYNC0  = 4'd0;
    localparam logic [3:0] POS_SYNC1  = 4'd1;
    localparam logic [3:0] POS_MARK   = 4'd2;
    localparam logic [3:0] POS_RSVD   = 4'd3;
    localparam logic [3:0] POS_ID     = 4'd4;
    localparam logic [3:0] POS_LEN_LO = 4'd5;
    localparam logic [3:0] POS_LEN_HI = 4'd6;
    localparam logic [3:0] POS_OPCODE = 4'd7;
    localparam logic [3:0] POS_ADDR   = 4'd8;
    localparam logic [3:0] POS_ADDR_H = 4'd9;
    localparam logic [3:0] POS_DATA   = 4'd10;

    // One classified command
    typedef struct packed {
        logic [7:0]                   servo_id;
        logic [7:0]                   reg_addr;
        logic [7:0]                   opcode;
        logic [7:0]                   len_lo;
        logic [2:0]                   data_count;
        logic [DATA_FIELDS-1:0][7:0]  data;
    } swpf_cmd_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        swpf_cmd_t cmd;
    } swpf_head_t;

    // MSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/swpf_front.sv
// Front end: opcode register, command accept, count clamp and length field.
module swpf_front #(
    parameter int unsigned MAX_DATA = swpf_pkg::MAX_DATA_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_servo_id,
    input  logic [7:0]         s_reg_addr,
    input  logic [2:0]         s_data_count,
    input  logic [7:0]         s_data_byte0,
    input  logic [7:0]         s_data_byte1,
    input  logic [7:0]         s_data_byte2,
    input  logic [7:0]         s_data_byte3,
    input  logic               q_full,
    output logic               q_push,
    output swpf_pkg::swpf_cmd_t q_entry
);
    import swpf_pkg::*;

    localparam int unsigned LIMIT = (MAX_DATA < DATA_FIELDS) ? MAX_DATA : DATA_FIELDS;

    logic [7:0] opcode_reg;
    logic [2:0] count_sat;

    // Hold the write opcode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opcode_reg <= 8'd3;
        end else if (cfg_wr_en) begin
            opcode_reg <= cfg_wr_data;
        end
    end

    // Clamp the data count to the supported limit
    always_comb begin
        count_sat = (s_data_count > 3'(LIMIT)) ? 3'(LIMIT) : s_data_count;
    end

    // Accept a beat whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Pack the classified command
    always_comb begin
        q_entry.servo_id   = s_servo_id;
        q_entry.reg_addr   = s_reg_addr;
        q_entry.opcode     = opcode_reg;
        q_entry.len_lo     = {5'd0, count_sat} + LEN_BASE;
        q_entry.data_count = count_sat;
        q_entry.data       = {s_data_byte3, s_data_byte2, s_data_byte1, s_data_byte0};
    end

endmodule

>>> hw/rtl/swpf_queue.sv
// Command queue between the front end and the byte sequencer.
module swpf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  swpf_pkg::swpf_cmd_t   push_entry,
    output logic                  full,
    input  logic                  pop,
    output swpf_pkg::swpf_head_t  head
);
    import swpf_pkg::*;

    swpf_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   level_reg;
    logic [QPTR_W:0]   level_next;

    assign full       = (level_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (level_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    // Write the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Track fill level
    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

endmodule

>>> hw/rtl/swpf_back.sv
// Back end: byte sequencer with running CRC-16 and output register.
module swpf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  swpf_pkg::swpf_head_t head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_tx_byte,
    output logic                 m_last_byte
);
    import swpf_pkg::*;

    `include "servo_write_packet_framer_assert.svh"

    logic [3:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        m_valid_reg;
    logic [7:0]  m_tx_byte_reg;
    logic        m_last_byte_reg;

    logic        out_adv;
    logic        step;
    logic [3:0]  data_end;
    logic [3:0]  crc_hi_idx;
    logic [3:0]  data_off;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic        emit_payload;

    // Packet boundaries for the current command
    assign data_end   = POS_DATA + {1'b0, head.cmd.data_count};
    assign crc_hi_idx = data_end + 4'd1;
    assign data_off   = idx_reg - POS_DATA;

    assign out_adv = !m_valid_reg || m_ready;
    assign step    = head.valid && out_adv;
    assign pop     = step && emit_last;

    // Select the byte at the current position
    always_comb begin
        emit_payload = 1'b1;
        emit_last    = 1'b0;
        case (idx_reg)
            POS_SYNC0:  emit_byte = HDR_SYNC;
            POS_SYNC1:  emit_byte = HDR_SYNC;
            POS_MARK:   emit_byte = HDR_MARK;
            POS_RSVD:   emit_byte = HDR_RSVD;
            POS_ID:     emit_byte = head.cmd.servo_id;
            POS_LEN_LO: emit_byte = head.cmd.len_lo;
            POS_LEN_HI: emit_byte = 8'h00;
            POS_OPCODE: emit_byte = head.cmd.opcode;
            POS_ADDR:   emit_byte = head.cmd.reg_addr;
            POS_ADDR_H: emit_byte = 8'h00;
            default: begin
                if (idx_reg < data_end) begin
                    emit_byte = head.cmd.data[data_off[1:0]];
                end else if (idx_reg == data_end) begin
                    emit_payload = 1'b0;
                    emit_byte    = crc_reg[7:0];
                end else begin
                    emit_payload = 1'b0;
                    emit_last    = 1'b1;
                    emit_byte    = crc_reg[15:8];
                end
            end
        endcase
    end

    // Advance position and fold payload bytes into the CRC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            crc_reg <= '0;
        end else if (step) begin
            if (emit_last) begin
                idx_reg <= '0;
                crc_reg <= '0;
            end else begin
                idx_reg <= idx_reg + 4'd1;
                if (emit_payload) begin
                    crc_reg <= crc16_byte(crc_reg, emit_byte);
                end
            end
        end
    end

    // Output register: load on advance, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= head.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tx_byte_reg   <= emit_byte;
            m_last_byte_reg <= emit_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tx_byte   = m_tx_byte_reg;
    assign m_last_byte = m_last_byte_reg;

    // Sequencer checks
    `SWPF_ASSERT_NEXT(a_wrap_clears, step && emit_last, idx_reg == '0 && crc_reg == '0, "sequencer did not restart after last beat")
    `SWPF_ASSERT_IMPL(a_idx_range, head.valid, idx_reg <= crc_hi_idx, "byte position beyond packet end")
    `SWPF_ASSERT_IMPL(a_crc_start, head.valid && idx_reg == '0, crc_reg == '0, "CRC not cleared at packet start")

endmodule

>>> hw/rtl/servo_write_packet_framer.sv
// The first byte of a packet passes through the command queue and then the output register.
// One byte per cycle while the receiver is ready; a packet is saturated count + 12 bytes (16 with four
// data bytes), set by the single byte sequencer and its output register.
// A two-entry command queue lets new commands in while a packet is still going out.
// Reset (aresetn low, synchronous): opcode register to 3, queue and output empty.
module servo_write_packet_framer #(
    parameter int unsigned MAX_DATA = swpf_pkg::MAX_DATA_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_servo_id,
    input  logic [7:0] s_reg_addr,
    input  logic [2:0] s_data_count,
    input  logic [7:0] s_data_byte0,
    input  logic [7:0] s_data_byte1,
    input  logic [7:0] s_data_byte2,
    input  logic [7:0] s_data_byte3,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_last_byte
);
    import swpf_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    swpf_cmd_t  q_entry;
    swpf_head_t q_head;

    // Accept and classify commands
    swpf_front #(
        .MAX_DATA(MAX_DATA)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_servo_id  (s_servo_id),
        .s_reg_addr  (s_reg_addr),
        .s_data_count(s_data_count),
        .s_data_byte0(s_data_byte0),
        .s_data_byte1(s_data_byte1),
        .s_data_byte2(s_data_byte2),
        .s_data_byte3(s_data_byte3),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    // Buffer pending commands
    swpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    // Stream out framed bytes
    swpf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_byte  (m_tx_byte),
        .m_last_byte(m_last_byte)
    );

endmodule

>>> tb/servo_write_packet_framer_tb.sv
// Self-checking testbench for the servo register-write packet framer.
module servo_write_packet_framer_tb;
    import swpf_pkg::*;

    localparam int unsigned DATA_LIMIT   = (MAX_DATA_DEF < DATA_FIELDS) ? MAX_DATA_DEF
                                                                         : DATA_FIELDS;
    localparam logic [7:0]  OPCODE_RESET = 8'd3;
    localparam int          NUM_DIR      = 17;
    localparam int          NUM_SEGMENTS = 6;
    localparam int          SEG_ITEMS    = 72;
    localparam int          LONG_HOLD    = 300;
    localparam int          SETTLE       = 4;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          CYCLE_LIMIT  = 1000000;

    // One register-write command as offered on the input channel
    typedef struct packed {
        logic [7:0] servo_id;
        logic [7:0] reg_addr;
        logic [2:0] data_count;
        logic [7:0] data_byte0;
        logic [7:0] data_byte1;
        logic [7:0] data_byte2;
        logic [7:0] data_byte3;
    } write_cmd_t;

    // One framed byte as seen on the result channel
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } pkt_byte_t;

    // Directed row: optional opcode write before it, command, packet length (0 = not given)
    typedef struct packed {
        logic       set_op;
        logic [7:0] opcode;
        write_cmd_t cmd;
        logic [4:0] pkt_len;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_servo_id;
    logic [7:0] s_reg_addr;
    logic [2:0] s_data_count;
    logic [7:0] s_data_byte0;
    logic [7:0] s_data_byte1;
    logic [7:0] s_data_byte2;
    logic [7:0] s_data_byte3;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_tx_byte;
    logic       m_last_byte;

    pkt_byte_t  tx_bytes_q [$];
    int         pkt_len_q [$];
    logic [7:0] opcode_shadow;
    int         byte_pos;
    int         mismatches;
    int         cycle_count;
    bit         quiet;
    bit         long_hold;

    dir_row_t dir_rows [NUM_DIR] = '{
        // reset opcode, smallest fields
        '{1'b0, 8'h00, '{8'h00, 8'h00, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00}, 5'd13},
        // largest fields
        '{1'b0, 8'h00, '{8'hFF, 8'hFF, 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 5'd16},
        // no data bytes
        '{1'b0, 8'h00, '{8'h01, 8'h02, 3'd0, 8'hAA, 8'hBB, 8'hCC, 8'hDD}, 5'd12},
        // counts above the limit saturate
        '{1'b0, 8'h00, '{8'h10, 8'h20, 3'd5, 8'h11, 8'h22, 8'h33, 8'h44}, 5'd16},
        '{1'b0, 8'h00, '{8'h10, 8'h20, 3'd6, 8'h55, 8'h66, 8'h77, 8'h88}, 5'd16},
        '{1'b0, 8'h00, '{8'h10, 8'h20, 3'd7, 8'h99, 8'hAA, 8'hBB, 8'hCC}, 5'd16},
        // unused data bytes carry junk
        '{1'b0, 8'h00, '{8'h7E, 8'h81, 3'd2, 8'h5A, 8'hA5, 8'hFF, 8'hFF}, 5'd14},
        '{1'b0, 8'h00, '{8'h33, 8'hCC, 3'd3, 8'h01, 8'h02, 8'h03, 8'hEE}, 5'd15},
        // opcode extremes
        '{1'b1, 8'hFF, '{8'h00, 8'h00, 3'd1, 8'h80, 8'h00, 8'h00, 8'h00}, 5'd13},
        '{1'b0, 8'h00, '{8'hFF, 8'h00, 3'd4, 8'h00, 8'hFF, 8'h00, 8'hFF}, 5'd16},
        '{1'b0, 8'h00, '{8'h55, 8'hAA, 3'd2, 8'h00, 8'h00, 8'h00, 8'h00}, 5'd0},
        '{1'b1, 8'h00, '{8'hAA, 8'h55, 3'd4, 8'h01, 8'h80, 8'h7F, 8'hFE}, 5'd16},
        '{1'b0, 8'h00, '{8'hFE, 8'h01, 3'd1, 8'h7F, 8'h00, 8'h00, 8'h00}, 5'd0},
        '{1'b0, 8'h00, '{8'h00, 8'hFF, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 5'd12},
        '{1'b1, 8'hA5, '{8'h5A, 8'h3C, 3'd3, 8'hC3, 8'h96, 8'h69, 8'h00}, 5'd0},
        '{1'b0, 8'h00, '{8'h01, 8'h01, 3'd4, 8'h12, 8'h34, 8'h56, 8'h78}, 5'd0},
        '{1'b1, 8'h03, '{8'h42, 8'h42, 3'd1, 8'h24, 8'h00, 8'h00, 8'h00}, 5'd0}
    };

    servo_write_packet_framer u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_servo_id   (s_servo_id),
        .s_reg_addr   (s_reg_addr),
        .s_data_count (s_data_count),
        .s_data_byte0 (s_data_byte0),
        .s_data_byte1 (s_data_byte1),
        .s_data_byte2 (s_data_byte2),
        .s_data_byte3 (s_data_byte3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_byte    (m_tx_byte),
        .m_last_byte  (m_last_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // MSB-first CRC-16, one bit at a time
    function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Build the framed packet for one command and queue its bytes
    function automatic void frame_write_cmd(input write_cmd_t c, input logic [7:0] opcode);
        logic [7:0]  pkt [16];
        logic [7:0]  data [4];
        logic [15:0] crc;
        int          n_data;
        int          n;
        n_data  = (int'(c.data_count) > int'(DATA_LIMIT)) ? int'(DATA_LIMIT)
                                                           : int'(c.data_count);
        data[0] = c.data_byte0;
        data[1] = c.data_byte1;
        data[2] = c.data_byte2;
        data[3] = c.data_byte3;
        pkt[0]  = HDR_SYNC;
        pkt[1]  = HDR_SYNC;
        pkt[2]  = HDR_MARK;
        pkt[3]  = HDR_RSVD;
        pkt[4]  = c.servo_id;
        pkt[5]  = LEN_BASE + 8'(n_data);
        pkt[6]  = 8'h00;
        pkt[7]  = opcode;
        pkt[8]  = c.reg_addr;
        pkt[9]  = 8'h00;
        for (int i = 0; i < n_data; i++) pkt[10 + i] = data[i];
        n   = 10 + n_data;
        crc = 16'h0000;
        for (int i = 0; i < n; i++) crc = crc_shift_byte(crc, pkt[i]);
        pkt[n]     = crc[7:0];
        pkt[n + 1] = crc[15:8];
        n += 2;
        for (int i = 0; i < n; i++) tx_bytes_q.push_back('{pkt[i], (i == n - 1)});
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Track the opcode, predict on each input beat, check each output beat
    always @(posedge aclk) begin
        pkt_byte_t want;
        int        want_len;
        if (!aresetn) begin
            opcode_shadow = OPCODE_RESET;
            byte_pos      = 0;
        end else begin
            if (s_valid && s_ready) begin
                frame_write_cmd('{s_servo_id, s_reg_addr, s_data_count, s_data_byte0,
                                  s_data_byte1, s_data_byte2, s_data_byte3}, opcode_shadow);
            end
            if (cfg_wr_en) opcode_shadow = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (tx_bytes_q.size() == 0) begin
                    report_mismatch("unexpected beat, tx_byte", int'(m_tx_byte), 0);
                end else begin
                    want = tx_bytes_q.pop_front();
                    if (m_tx_byte !== want.tx_byte)
                        report_mismatch($sformatf("tx_byte at pos %0d", byte_pos),
                                        int'(m_tx_byte), int'(want.tx_byte));
                    if (m_last_byte !== want.last_byte)
                        report_mismatch($sformatf("last_byte at pos %0d", byte_pos),
                                        int'(m_last_byte), int'(want.last_byte));
                end
                if (m_last_byte === 1'b1) begin
                    want_len = (pkt_len_q.size() != 0) ? pkt_len_q.pop_front() : 0;
                    if (want_len != 0 && byte_pos + 1 != want_len)
                        report_mismatch("packet length", byte_pos + 1, want_len);
                    byte_pos = 0;
                end else begin
                    byte_pos++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (long_hold) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Wait for all packets to drain, then write the opcode register
    task automatic program_opcode(input logic [7:0] value);
        s_valid = 1'b0;
        while (tx_bytes_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Offer one command beat, optionally after a random gap, and hold it until taken
    task automatic send_write_cmd(input write_cmd_t c, input int pkt_len);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_servo_id   = c.servo_id;
        s_reg_addr   = c.reg_addr;
        s_data_count = c.data_count;
        s_data_byte0 = c.data_byte0;
        s_data_byte1 = c.data_byte1;
        s_data_byte2 = c.data_byte2;
        s_data_byte3 = c.data_byte3;
        s_valid      = 1'b1;
        pkt_len_q.push_back(pkt_len);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        write_cmd_t cmd;
        logic [7:0] seg_opcodes [NUM_SEGMENTS];
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 8'h00;
        s_valid      = 1'b0;
        s_servo_id   = 8'h00;
        s_reg_addr   = 8'h00;
        s_data_count = 3'd0;
        s_data_byte0 = 8'h00;
        s_data_byte1 = 8'h00;
        s_data_byte2 = 8'h00;
        s_data_byte3 = 8'h00;
        quiet        = 1'b0;
        long_hold    = 1'b0;
        mismatches   = 0;
        cycle_count  = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed rows
        for (int r = 0; r < NUM_DIR; r++) begin
            if (dir_rows[r].set_op) program_opcode(dir_rows[r].opcode);
            send_write_cmd(dir_rows[r].cmd, int'(dir_rows[r].pkt_len));
        end

        // Random segments, one opcode setting each
        seg_opcodes[0] = 8'h00;
        seg_opcodes[1] = 8'hFF;
        seg_opcodes[2] = 8'($urandom);
        seg_opcodes[3] = 8'($urandom);
        seg_opcodes[4] = OPCODE_RESET;
        seg_opcodes[5] = 8'($urandom);
        for (int s = 0; s < NUM_SEGMENTS; s++) begin
            program_opcode(seg_opcodes[s]);
            if (s == NUM_SEGMENTS - 1) quiet = 1'b1;
            for (int i = 0; i < SEG_ITEMS; i++) begin
                // stall the receiver for a long stretch while commands keep coming
                if (s == 1 && i == 5) long_hold = 1'b1;
                cmd.servo_id   = 8'($urandom);
                cmd.reg_addr   = 8'($urandom);
                cmd.data_count = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                                            : 3'($urandom_range(0, 7));
                cmd.data_byte0 = 8'($urandom);
                cmd.data_byte1 = 8'($urandom);
                cmd.data_byte2 = 8'($urandom);
                cmd.data_byte3 = 8'($urandom);
                send_write_cmd(cmd, 0);
            end
        end

        // Drain and finish
        s_valid = 1'b0;
        while (tx_bytes_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tx_bytes_q.size() != 0) report_mismatch("bytes left over", tx_bytes_q.size(), 0);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
